// File: rtl/fgr_pkg.sv
// ----------------------------------------------------------------------------
// fgr_pkg: shared types and constants for the fraction GCD reduction unit
// Holds the operand and result beat layouts, the sequencer states and the
// default machine word width.
// ----------------------------------------------------------------------------
package fgr_pkg;

  // Width of every numeric field on the ports.
  localparam int FIELD_BITS = 64;

  // Default machine word width used inside the unit.
  localparam int WORD_BITS_DEFAULT = 64;

  typedef logic [FIELD_BITS-1:0] field_t;

  // Status codes.
  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_ZERO_DEN = 1'b1
  } status_t;

  // One operand beat.
  typedef struct packed {
    field_t numerator;
    field_t denominator;
  } operands_t;

  // One result beat.
  typedef struct packed {
    field_t  reduced_numerator;
    field_t  reduced_denominator;
    field_t  common_divisor;
    status_t status;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV_NUM,
    ST_DIV_DEN
  } state_t;

endpackage

// File: rtl/fraction_gcd_reduce_unit.sv
// ----------------------------------------------------------------------------
// fraction_gcd_reduce_unit: reduces a fraction to lowest terms
// Finds the greatest common divisor of the numerator and denominator with a
// binary GCD loop, then divides both values by it with a restoring divider.
// Every subtract step of both phases runs through one shared subtractor.
//
//   Channel   Handshake           Payload      Direction
//   --------  ------------------  -----------  ---------
//   command   start, busy         operands     in
//   result    done (strobe)       result       out
//
// A zero denominator, a zero numerator or equal values give a result in the
// cycle after the command beat. Otherwise the GCD loop does one subtract,
// swap or shift per cycle, the divisor is scaled back by the common power of
// two, and the two divisions run one quotient bit per cycle in the shared
// subtractor. busy is high while a general-case command is in work and
// drops as its result beat appears; the cases above never raise it. rst is
// synchronous and returns the unit to idle. The receiver cannot stall: each
// result is marked by done, high for exactly one cycle.
// ----------------------------------------------------------------------------
module fraction_gcd_reduce_unit #(
  parameter int WORD_BITS = fgr_pkg::WORD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fgr_pkg::operands_t operands,
  output logic               done,
  output fgr_pkg::result_t   result
);

  localparam int KW = $clog2(WORD_BITS);
  localparam int SW = WORD_BITS + 2;

  fgr_pkg::state_t state, state_next;

  logic [WORD_BITS-1:0] a, a_next;
  logic [WORD_BITS-1:0] b, b_next;
  logic [KW-1:0]        k, k_next;
  logic [KW-1:0]        cnt, cnt_next;
  logic [WORD_BITS-1:0] numr, numr_next;
  logic [WORD_BITS-1:0] denr, denr_next;
  logic [WORD_BITS-1:0] rem, rem_next;
  logic [WORD_BITS-1:0] quo, quo_next;
  logic [WORD_BITS-1:0] qnum, qnum_next;
  fgr_pkg::result_t     result_next;
  logic                 done_next;

  logic [WORD_BITS-1:0] in_num, in_den;
  logic [SW-1:0]        sub_x, sub_y, sub_d;
  logic                 borrow;
  logic                 accept;
  logic                 special;
  logic                 div_state;

  // Masked operands and the command handshake.
  assign in_num  = operands.numerator[WORD_BITS-1:0];
  assign in_den  = operands.denominator[WORD_BITS-1:0];
  assign busy    = (state != fgr_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign special = (in_den == '0) || (in_num == '0) || (in_num == in_den);

  // Shared subtractor: b - a in the GCD loop, partial remainder minus the
  // divisor in the divisions.
  assign div_state = (state == fgr_pkg::ST_DIV_NUM) || (state == fgr_pkg::ST_DIV_DEN);
  always_comb begin
    if (div_state) begin
      sub_x = {1'b0, rem, quo[WORD_BITS-1]};
      sub_y = {2'b00, a};
    end else begin
      sub_x = {2'b00, b};
      sub_y = {2'b00, a};
    end
  end
  assign sub_d  = sub_x - sub_y;
  assign borrow = sub_d[SW-1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fgr_pkg::ST_IDLE: begin
        if (accept && !special) state_next = fgr_pkg::ST_GCD;
      end
      fgr_pkg::ST_GCD: begin
        if (b == '0) state_next = fgr_pkg::ST_SCALE;
      end
      fgr_pkg::ST_SCALE: begin
        if (k == '0) state_next = fgr_pkg::ST_DIV_NUM;
      end
      fgr_pkg::ST_DIV_NUM: begin
        if (cnt == '0) state_next = fgr_pkg::ST_DIV_DEN;
      end
      fgr_pkg::ST_DIV_DEN: begin
        if (cnt == '0) state_next = fgr_pkg::ST_IDLE;
      end
      default: state_next = fgr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    a_next      = a;
    b_next      = b;
    k_next      = k;
    cnt_next    = cnt;
    numr_next   = numr;
    denr_next   = denr;
    rem_next    = rem;
    quo_next    = quo;
    qnum_next   = qnum;
    result_next = result;
    done_next   = 1'b0;
    unique case (state)
      fgr_pkg::ST_IDLE: begin
        if (accept) begin
          numr_next = in_num;
          denr_next = in_den;
          a_next    = in_num;
          b_next    = in_den;
          k_next    = '0;
          priority if (in_den == '0) begin
            result_next.reduced_numerator   = fgr_pkg::field_t'(in_num);
            result_next.reduced_denominator = '0;
            result_next.common_divisor      = '0;
            result_next.status              = fgr_pkg::STATUS_ZERO_DEN;
            done_next                       = 1'b1;
          end else if (in_num == '0) begin
            result_next.reduced_numerator   = '0;
            result_next.reduced_denominator = fgr_pkg::field_t'(in_den);
            result_next.common_divisor      = '0;
            result_next.status              = fgr_pkg::STATUS_OK;
            done_next                       = 1'b1;
          end else if (in_num == in_den) begin
            result_next.reduced_numerator   = fgr_pkg::field_t'(1);
            result_next.reduced_denominator = fgr_pkg::field_t'(1);
            result_next.common_divisor      = fgr_pkg::field_t'(in_num);
            result_next.status              = fgr_pkg::STATUS_OK;
            done_next                       = 1'b1;
          end else begin
            // General case: the GCD loop produces the result later.
            done_next = 1'b0;
          end
        end
      end
      fgr_pkg::ST_GCD: begin
        // One binary GCD step; a stays nonzero throughout.
        priority if (b == '0) begin
          a_next = a;
        end else if (!a[0] && !b[0]) begin
          a_next = a >> 1;
          b_next = b >> 1;
          k_next = k + 1'b1;
        end else if (!a[0]) begin
          a_next = a >> 1;
        end else if (!b[0]) begin
          b_next = b >> 1;
        end else if (borrow) begin
          a_next = b;
          b_next = a;
        end else begin
          b_next = sub_d[WORD_BITS-1:0];
        end
      end
      fgr_pkg::ST_SCALE: begin
        // Restore the common power of two, then set up the first division.
        if (k == '0) begin
          rem_next = '0;
          quo_next = numr;
          cnt_next = KW'(WORD_BITS - 1);
        end else begin
          a_next = a << 1;
          k_next = k - 1'b1;
        end
      end
      fgr_pkg::ST_DIV_NUM, fgr_pkg::ST_DIV_DEN: begin
        // One restoring division step per cycle.
        if (borrow) begin
          rem_next = sub_x[WORD_BITS-1:0];
          quo_next = {quo[WORD_BITS-2:0], 1'b0};
        end else begin
          rem_next = sub_d[WORD_BITS-1:0];
          quo_next = {quo[WORD_BITS-2:0], 1'b1};
        end
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          if (state == fgr_pkg::ST_DIV_NUM) begin
            qnum_next = quo_next;
            rem_next  = '0;
            quo_next  = denr;
            cnt_next  = KW'(WORD_BITS - 1);
          end else begin
            result_next.reduced_numerator   = fgr_pkg::field_t'(qnum);
            result_next.reduced_denominator = fgr_pkg::field_t'(quo_next);
            result_next.common_divisor      = fgr_pkg::field_t'(a);
            result_next.status              = fgr_pkg::STATUS_OK;
            done_next                       = 1'b1;
          end
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fgr_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a      <= a_next;
    b      <= b_next;
    k      <= k_next;
    cnt    <= cnt_next;
    numr   <= numr_next;
    denr   <= denr_next;
    rem    <= rem_next;
    quo    <= quo_next;
    qnum   <= qnum_next;
    result <= result_next;
  end

`ifndef SYNTH
  // A result beat never appears while a command is still in progress.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // The GCD operand and divisor must never be zero once work has started.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (a != '0))
    else $error("zero divisor in GCD or division phase");

  // A zero-denominator beat reports no common divisor.
  a_error_no_divisor: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == fgr_pkg::STATUS_ZERO_DEN)) |-> (result.common_divisor == '0))
    else $error("common divisor reported with zero denominator");
`endif

endmodule

// File: tb/sv/fraction_gcd_reduce_checker.sv
// ----------------------------------------------------------------------------
// fraction_gcd_reduce_checker: result predictor and comparator
// Watches the command and result channels of the fraction reduction unit.
// Each accepted command beat is reduced to lowest terms here and the
// prediction is queued. Each result beat is compared field by field with
// the oldest prediction. The failure tally and the number of predictions
// still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module fraction_gcd_reduce_checker #(
  parameter int WORD_BITS = fgr_pkg::WORD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  fgr_pkg::operands_t operands,
  input  logic               done,
  input  fgr_pkg::result_t   result,
  output int                 fail_count,
  output int                 pending
);

  // Predicted result beats, oldest first.
  fgr_pkg::result_t reduced_fractions[$];
  int               tally = 0;

  // Euclidean GCD with the larger value as the first operand.
  function automatic fgr_pkg::field_t euclid_divisor(fgr_pkg::field_t x,
                                                     fgr_pkg::field_t y);
    fgr_pkg::field_t big;
    fgr_pkg::field_t little;
    fgr_pkg::field_t rem;
    big    = (x < y) ? y : x;
    little = (x < y) ? x : y;
    while (little != 0) begin
      rem    = big % little;
      big    = little;
      little = rem;
    end
    return big;
  endfunction

  // Reduces one operand beat to the result beat the unit should give.
  function automatic fgr_pkg::result_t reduce_fraction(fgr_pkg::operands_t op);
    fgr_pkg::field_t  all_ones;
    fgr_pkg::field_t  mask;
    fgr_pkg::field_t  num;
    fgr_pkg::field_t  den;
    fgr_pkg::field_t  g;
    fgr_pkg::result_t r;
    all_ones = '1;
    mask     = all_ones >> (fgr_pkg::FIELD_BITS - WORD_BITS);
    num      = op.numerator & mask;
    den      = op.denominator & mask;
    if (den == 0) begin
      // A zero denominator is an error; the numerator passes through.
      r.reduced_numerator   = num;
      r.reduced_denominator = '0;
      r.common_divisor      = '0;
      r.status              = fgr_pkg::STATUS_ZERO_DEN;
    end else if (num == 0) begin
      // A zero numerator passes through unreduced.
      r.reduced_numerator   = '0;
      r.reduced_denominator = den;
      r.common_divisor      = '0;
      r.status              = fgr_pkg::STATUS_OK;
    end else if (num == den) begin
      // Equal values give one over one at once.
      r.reduced_numerator   = fgr_pkg::field_t'(1);
      r.reduced_denominator = fgr_pkg::field_t'(1);
      r.common_divisor      = num;
      r.status              = fgr_pkg::STATUS_OK;
    end else begin
      g                     = euclid_divisor(num, den);
      r.reduced_numerator   = num / g;
      r.reduced_denominator = den / g;
      r.common_divisor      = g;
      r.status              = fgr_pkg::STATUS_OK;
    end
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(string name, fgr_pkg::field_t want, fgr_pkg::field_t got);
    if (want !== got) begin
      $error("%s: expected 0x%016h, actual 0x%016h", name, want, got);
      tally++;
    end
  endtask

  // Result beats are checked before a command beat at the same edge is queued.
  always @(posedge clk) begin
    fgr_pkg::result_t want;
    if (!rst) begin
      if (done) begin
        if (reduced_fractions.size() == 0) begin
          $error("result beat with no prediction waiting");
          tally++;
        end else begin
          want = reduced_fractions.pop_front();
          compare_field("reduced_numerator", want.reduced_numerator,
                        result.reduced_numerator);
          compare_field("reduced_denominator", want.reduced_denominator,
                        result.reduced_denominator);
          compare_field("common_divisor", want.common_divisor,
                        result.common_divisor);
          if (want.status !== result.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            tally++;
          end
        end
      end
      if (start && !busy) begin
        reduced_fractions.push_back(reduce_fraction(operands));
      end
    end
    fail_count <= tally;
    pending    <= reduced_fractions.size();
  end

endmodule

// File: tb/sv/fraction_gcd_reduce_unit_test.sv
// ----------------------------------------------------------------------------
// fraction_gcd_reduce_unit_test: testbench top for the fraction reduction unit
// Drives a directed set of fractions (extremes, zero operands, equal values,
// worst-case Euclid pairs) and then several hundred random fractions shaped
// towards shared factors, multiples and small values, with random idle
// bursts. A checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module fraction_gcd_reduce_unit_test;

  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_TAIL    = 60;

  logic               clk;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  fgr_pkg::operands_t operands = '0;
  logic               busy;
  logic               done;
  fgr_pkg::result_t   result;
  int                 fail_count;
  int                 pending;

  fraction_gcd_reduce_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  fraction_gcd_reduce_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operands   (operands),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung unit.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic fgr_pkg::field_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random value of at most n bits, n from 1 to 64.
  function automatic fgr_pkg::field_t rand_bits(int n);
    return rand_word() >> (fgr_pkg::FIELD_BITS - n);
  endfunction

  // Fibonacci number; consecutive pairs are the slowest case for Euclid.
  function automatic fgr_pkg::field_t fib(int n);
    fgr_pkg::field_t a;
    fgr_pkg::field_t b;
    fgr_pkg::field_t t;
    a = '0;
    b = 64'd1;
    repeat (n) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Presents one command beat and holds it until the unit takes it.
  task automatic send_fraction(fgr_pkg::field_t num, fgr_pkg::field_t den);
    start    <= 1'b1;
    operands <= '{numerator: num, denominator: den};
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random fraction, mostly shaped towards interesting divisors.
  task automatic random_fraction();
    fgr_pkg::field_t a;
    fgr_pkg::field_t b;
    fgr_pkg::field_t g;
    int              k;
    case ($urandom_range(0, 9))
      0, 1: begin
        send_fraction(rand_word(), rand_word());
      end
      2, 3: begin
        g = rand_bits($urandom_range(1, 32));
        a = rand_bits($urandom_range(1, 32));
        b = rand_bits($urandom_range(1, 32));
        send_fraction(a * g, b * g);
      end
      4: begin
        send_fraction(fgr_pkg::field_t'($urandom_range(0, 20)),
                      fgr_pkg::field_t'($urandom_range(0, 20)));
      end
      5: begin
        a = rand_bits($urandom_range(1, 64));
        send_fraction(a, a);
      end
      6: begin
        a = rand_bits($urandom_range(1, 64));
        if ($urandom_range(0, 1)) send_fraction('0, a);
        else send_fraction(a, '0);
      end
      7: begin
        k = $urandom_range(1, 92);
        if ($urandom_range(0, 1)) send_fraction(fib(k + 1), fib(k));
        else send_fraction(fib(k), fib(k + 1));
      end
      8: begin
        a = rand_bits(8) << $urandom_range(0, 56);
        b = rand_bits(8) << $urandom_range(0, 56);
        send_fraction(a, b);
      end
      default: begin
        a = rand_bits($urandom_range(1, 32));
        b = a * rand_bits($urandom_range(1, 32));
        if ($urandom_range(0, 1)) send_fraction(a, b);
        else send_fraction(b, a);
      end
    endcase
  endtask

  // Stimulus and verdict.
  initial begin
    fgr_pkg::field_t all_ones;
    all_ones = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: extremes, zero operands, equal values, slow pairs.
    send_fraction(all_ones, all_ones);
    send_fraction(all_ones, 64'd1);
    send_fraction(64'd1, all_ones);
    send_fraction(64'd1, 64'd1);
    send_fraction('0, '0);
    send_fraction('0, 64'd5);
    send_fraction(64'd5, '0);
    send_fraction(all_ones, '0);
    send_fraction('0, all_ones);
    send_fraction(64'd7, 64'd7);
    send_fraction(64'd12, 64'd18);
    send_fraction(all_ones, all_ones - 64'd1);
    send_fraction(64'd1 << 63, 64'd1 << 62);
    send_fraction(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_fraction(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_fraction(fib(93), fib(92));
    send_fraction(fib(92), fib(93));
    send_fraction(64'd18446744073709551557, 64'd4294967291);
    send_fraction(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);

    // The sender holds off until the unit is completely idle.
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      random_fraction();
      if (i == RANDOM_ITEMS / 2) begin
        drain();
      end else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        // Idle burst, sometimes placed after the result beat has gone.
        if ($urandom_range(0, 3) == 0) drain();
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fgr_pkg.sv
rtl/fraction_gcd_reduce_unit.sv
tb/sv/fraction_gcd_reduce_checker.sv
tb/sv/fraction_gcd_reduce_unit_test.sv
